[design/prce_pkg.sv]
// shared types, codes and helpers for the palette ram color encoder
package prce_pkg;

  localparam int PAL_AW    = 9;
  localparam int PAL_DW    = 9;
  localparam int PAL_DEPTH = 512;

  // transaction kinds; code 3 has no meaning and is served by default arms
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // bus register ports
  localparam logic [1:0] PORT_ADDR_LO = 2'd0;
  localparam logic [1:0] PORT_ADDR_HI = 2'd1;
  localparam logic [1:0] PORT_DATA_LO = 2'd2;
  localparam logic [1:0] PORT_DATA_HI = 2'd3;

  localparam logic [PAL_AW-1:0] PAL_LAST = PAL_AW'(PAL_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // one write port and one read port of the palette memory
  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] waddr;
    logic [PAL_DW-1:0] wdata;
    logic              re;
    logic [PAL_AW-1:0] raddr;
  } mem_req_t;

  // three-bit level times 36, as 32*f + 4*f
  function automatic logic [7:0] expand_level(input logic [2:0] f);
    expand_level = {f, 5'b00000} + {3'b000, f, 2'b00};
  endfunction

endpackage

[design/prce_mem.sv]
// palette storage: 512 x 9 synchronous ram, one write and one registered read port
module prce_mem (
  input  logic                           clk,
  input  prce_pkg::mem_req_t             req,
  output logic [prce_pkg::PAL_DW-1:0]    rdata
);

  logic [prce_pkg::PAL_DW-1:0] mem [prce_pkg::PAL_DEPTH];
  logic [prce_pkg::PAL_DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/prce_ctrl.sv]
// sequencer: clear sweep, transaction capture, read-modify-write and result registers
module prce_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_mode,
  input  logic [1:0]                     in_port,
  input  logic [7:0]                     in_write_data,
  input  logic [8:0]                     in_pixel_index,
  output prce_pkg::mem_req_t             mem_req,
  input  logic [prce_pkg::PAL_DW-1:0]    mem_rdata,
  output logic                           out_valid,
  output logic [7:0]                     out_read_data,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue
);

  prce_pkg::state_t state_r, state_nxt;

  logic [prce_pkg::PAL_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [prce_pkg::PAL_AW-1:0] addr_r, addr_nxt;
  logic [1:0]                  clk_sel_r, clk_sel_nxt;

  logic [1:0] mode_r;
  logic [1:0] port_r;
  logic [7:0] wd_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] read_data_r, read_data_nxt;
  logic [7:0] red_r, red_nxt;
  logic [7:0] green_r, green_nxt;
  logic [7:0] blue_r, blue_nxt;

  logic                        accept;
  logic                        exec;
  logic                        wr_en;
  logic [prce_pkg::PAL_DW-1:0] wr_data;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prce_pkg::ST_CLEAR: begin
        if (clr_cnt_r == prce_pkg::PAL_LAST) state_nxt = prce_pkg::ST_IDLE;
      end
      prce_pkg::ST_IDLE: begin
        if (start) state_nxt = prce_pkg::ST_EXEC;
      end
      prce_pkg::ST_EXEC: state_nxt = prce_pkg::ST_IDLE;
      default: state_nxt = prce_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    busy        = 1'b1;
    accept      = 1'b0;
    exec        = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    mem_req     = '0;
    case (state_r)
      prce_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
        mem_req.wdata = '0;
        clr_cnt_nxt   = clr_cnt_r + prce_pkg::PAL_AW'(1);
      end
      prce_pkg::ST_IDLE: begin
        busy        = 1'b0;
        accept      = start;
        mem_req.re  = start;
        mem_req.raddr = (in_mode == prce_pkg::MODE_LOOKUP) ? in_pixel_index : addr_r;
      end
      prce_pkg::ST_EXEC: begin
        exec          = 1'b1;
        mem_req.we    = wr_en;
        mem_req.waddr = addr_r;
        mem_req.wdata = wr_data;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // datapath of the executing transaction
  always_comb begin
    addr_nxt      = addr_r;
    clk_sel_nxt   = clk_sel_r;
    wr_en         = 1'b0;
    wr_data       = mem_rdata;
    out_valid_nxt = exec;
    read_data_nxt = '0;
    red_nxt       = '0;
    green_nxt     = '0;
    blue_nxt      = '0;
    if (exec) begin
      case (mode_r)
        prce_pkg::MODE_WRITE: begin
          case (port_r)
            prce_pkg::PORT_ADDR_LO: addr_nxt = {addr_r[8], wd_r};
            prce_pkg::PORT_ADDR_HI: begin
              addr_nxt    = {wd_r[0], addr_r[7:0]};
              clk_sel_nxt = wd_r[3:2];
            end
            prce_pkg::PORT_DATA_LO: begin
              wr_en   = 1'b1;
              wr_data = {mem_rdata[8], wd_r};
            end
            default: begin
              wr_en    = 1'b1;
              wr_data  = {wd_r[0], mem_rdata[7:0]};
              addr_nxt = addr_r + prce_pkg::PAL_AW'(1);
            end
          endcase
        end
        prce_pkg::MODE_READ: begin
          case (port_r)
            prce_pkg::PORT_ADDR_LO: read_data_nxt = addr_r[7:0];
            prce_pkg::PORT_ADDR_HI: read_data_nxt = {4'b0000, clk_sel_r, 1'b0, addr_r[8]};
            prce_pkg::PORT_DATA_LO: read_data_nxt = mem_rdata[7:0];
            default: begin
              read_data_nxt = {7'b0000000, mem_rdata[8]};
              addr_nxt      = addr_r + prce_pkg::PAL_AW'(1);
            end
          endcase
        end
        prce_pkg::MODE_LOOKUP: begin
          blue_nxt  = prce_pkg::expand_level(mem_rdata[2:0]);
          red_nxt   = prce_pkg::expand_level(mem_rdata[5:3]);
          green_nxt = prce_pkg::expand_level(mem_rdata[8:6]);
        end
        default: begin
          read_data_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prce_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      addr_r      <= '0;
      clk_sel_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      addr_r      <= addr_nxt;
      clk_sel_r   <= clk_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      port_r <= in_port;
      wd_r   <= in_write_data;
    end
    read_data_r <= read_data_nxt;
    red_r       <= red_nxt;
    green_r     <= green_nxt;
    blue_r      <= blue_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = read_data_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prce_pkg::ST_CLEAR && clr_cnt_r == prce_pkg::PAL_LAST)
      |=> state_r == prce_pkg::ST_IDLE)
    else $error("clear sweep did not finish after the last entry");

  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == prce_pkg::ST_CLEAR || state_r == prce_pkg::ST_EXEC))
    else $error("palette written outside clear sweep or execution");

  a_addr_stable_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prce_pkg::ST_EXEC) |-> $stable(addr_r))
    else $error("palette address moved between read and write back");

endmodule

[design/palette_ram_color_encoder.sv]
// top level of the indexed color palette ram with byte bus and pixel lookup
//
// usage:
//   a transaction is accepted at a rising edge where start is high and busy low.
//   in_mode picks a bus write, a bus read or a pixel lookup; in_port selects the
//   bus register (address low, address high plus clock mode, entry low, entry
//   high), in_write_data is the written byte and in_pixel_index the looked-up entry.
//   every transaction, including an undefined mode, yields exactly one result:
//   out_valid is high for one cycle with out_read_data, out_red, out_green and
//   out_blue. the receiver cannot stall, so results are never held back.
// timing:
//   the accepting edge moves the sequencer to its execute state, and the result
//   strobe is registered out of that state. the palette is one synchronous ram
//   with a registered read, and each transaction reads its entry then writes it
//   back, so busy stays high after each accept during the execute state: a new
//   transaction is taken only once the previous one has been written back.
// reset:
//   rst_n clears the address and clock mode, then a clearing pass zeroes all 512
//   palette entries, one per cycle; busy is high throughout the pass.
module palette_ram_color_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_port,
  input  logic [7:0] in_write_data,
  input  logic [8:0] in_pixel_index,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  // memory request from the sequencer and registered read data back
  prce_pkg::mem_req_t              mem_req;
  logic [prce_pkg::PAL_DW-1:0]     mem_rdata;

  // sequencer owns the address register, clock mode and result registers
  prce_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_port        (in_port),
    .in_write_data  (in_write_data),
    .in_pixel_index (in_pixel_index),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  // palette entries: blue in bits 2:0, red in 5:3, green in 8:6
  prce_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

[tb/tb_palette_ram_color_encoder.sv]
// self-checking testbench for the palette ram color encoder: bus and lookup transactions
`timescale 1ns / 1ps

module tb_palette_ram_color_encoder;

  // code 3 of the mode field has no meaning; the block must return all zeros
  localparam logic [1:0] MODE_NONE = 2'd3;

  // limits of the run
  localparam int RANDOM_TXNS  = 1500;
  localparam int QUIET_LIMIT  = 3000;  // covers the clearing pass of all 512 entries after reset
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  // one bus or lookup transaction plus the idle cycles to leave before it
  typedef struct {
    logic [1:0]  mode;
    logic [1:0]  port;
    logic [7:0]  wdata;
    logic [8:0]  pix;
    int unsigned gap;
  } bus_txn_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_result_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       start          = 1'b0;
  logic       busy;
  logic [1:0] in_mode        = '0;
  logic [1:0] in_port        = '0;
  logic [7:0] in_write_data  = '0;
  logic [8:0] in_pixel_index = '0;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // transactions waiting to be driven, and colors waiting to come back
  bus_txn_t      pending_txns[$];
  bus_txn_t      cur_txn;
  color_result_t expected_colors[$];

  // shadow copy of the palette state
  logic [8:0] pal_shadow [prce_pkg::PAL_DEPTH];
  logic [8:0] addr_shadow;
  logic [1:0] clksel_shadow;

  int          hold_cycles    = 0;
  int          quiet_cycles   = 0;
  int          mismatch_count = 0;
  int unsigned gap_max        = 0;

  palette_ram_color_encoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_port        (in_port),
    .in_write_data  (in_write_data),
    .in_pixel_index (in_pixel_index),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // three-bit palette field stretched to an 8-bit level
  function automatic logic [7:0] times36(logic [2:0] f);
    return {5'b00000, f} * 8'd36;
  endfunction

  // advance the shadow state by one transaction and return the color it yields
  function automatic color_result_t predict_color(bus_txn_t t);
    color_result_t r;
    logic [8:0]    entry;
    r = '0;
    case (t.mode)
      prce_pkg::MODE_WRITE: begin
        case (t.port)
          prce_pkg::PORT_ADDR_LO: addr_shadow[7:0] = t.wdata;
          prce_pkg::PORT_ADDR_HI: begin
            // only bit 0 and the clock mode bits survive
            addr_shadow[8] = t.wdata[0];
            clksel_shadow  = t.wdata[3:2];
          end
          prce_pkg::PORT_DATA_LO: pal_shadow[addr_shadow][7:0] = t.wdata;
          default: begin
            // entry bit 8, then the address steps on and wraps at 512
            pal_shadow[addr_shadow][8] = t.wdata[0];
            addr_shadow = addr_shadow + 9'd1;
          end
        endcase
      end
      prce_pkg::MODE_READ: begin
        case (t.port)
          prce_pkg::PORT_ADDR_LO: r.read_data = addr_shadow[7:0];
          prce_pkg::PORT_ADDR_HI:
            r.read_data = {4'b0000, clksel_shadow, 1'b0, addr_shadow[8]};
          prce_pkg::PORT_DATA_LO: r.read_data = pal_shadow[addr_shadow][7:0];
          default: begin
            r.read_data = {7'b0000000, pal_shadow[addr_shadow][8]};
            addr_shadow = addr_shadow + 9'd1;
          end
        endcase
      end
      prce_pkg::MODE_LOOKUP: begin
        entry   = pal_shadow[t.pix];
        r.blue  = times36(entry[2:0]);
        r.red   = times36(entry[5:3]);
        r.green = times36(entry[8:6]);
      end
      default: ;  // undefined mode: state untouched, zero result
    endcase
    return r;
  endfunction

  task automatic push_txn(logic [1:0] m, logic [1:0] p, logic [7:0] d, logic [8:0] x);
    bus_txn_t t;
    t.mode  = m;
    t.port  = p;
    t.wdata = d;
    t.pix   = x;
    t.gap   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    pending_txns.push_back(t);
  endtask

  task automatic note_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // put the next queued transaction on the input ports
  task automatic launch_next();
    cur_txn = pending_txns.pop_front();
    in_mode        <= cur_txn.mode;
    in_port        <= cur_txn.port;
    in_write_data  <= cur_txn.wdata;
    in_pixel_index <= cur_txn.pix;
    start          <= 1'b1;
  endtask

  // driver: a transaction is taken when start is high and busy low at the edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start       <= 1'b0;
      hold_cycles = 0;
      addr_shadow   = '0;
      clksel_shadow = '0;
      for (int i = 0; i < prce_pkg::PAL_DEPTH; i++) pal_shadow[i] = '0;
    end else if (start && !busy) begin
      expected_colors.push_back(predict_color(cur_txn));
      // back to back when the next transaction wants no gap
      if (pending_txns.size() != 0 && pending_txns[0].gap == 0) begin
        launch_next();
      end else begin
        start <= 1'b0;
        if (pending_txns.size() != 0) hold_cycles = pending_txns[0].gap - 1;
      end
    end else if (!start) begin
      if (hold_cycles != 0) begin
        hold_cycles--;
      end else if (pending_txns.size() != 0) begin
        launch_next();
      end
    end
  end

  // monitor and watchdog: every strobe carries one result that cannot be held off
  always @(posedge clk) begin
    color_result_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** palette_ram_color_encoder: FAILED **");
        $finish;
      end else if (out_valid) begin
        if (expected_colors.size() == 0) begin
          note_error($sformatf("result with none pending: rd=%02h r=%0d g=%0d b=%0d",
                               out_read_data, out_red, out_green, out_blue));
        end else begin
          want = expected_colors.pop_front();
          if (out_read_data !== want.read_data || out_red !== want.red ||
              out_green !== want.green || out_blue !== want.blue) begin
            note_error($sformatf("mismatch: rd=%02h/%02h r=%0d/%0d g=%0d/%0d b=%0d/%0d (got/exp)",
                                 out_read_data, want.read_data, out_red, want.red,
                                 out_green, want.green, out_blue, want.blue));
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int unsigned base;
    int unsigned n;
    int unsigned kind;

    // directed part, no idling
    gap_max = 0;
    // cleared palette, first and last entry
    push_txn(prce_pkg::MODE_LOOKUP, prce_pkg::PORT_ADDR_LO, 8'h00, 9'h000);
    push_txn(prce_pkg::MODE_LOOKUP, prce_pkg::PORT_DATA_HI, 8'hFF, 9'h1FF);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_ADDR_LO, 8'h00, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_ADDR_HI, 8'h00, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_DATA_LO, 8'h00, 9'h000);
    // stray bits dropped, clock mode 3
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_ADDR_HI, 8'hFF, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_ADDR_HI, 8'h00, 9'h000);
    // address 511
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_ADDR_LO, 8'hFF, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_ADDR_LO, 8'h00, 9'h000);
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_DATA_LO, 8'hFF, 9'h000);
    // only bit 0 kept, address wraps
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_DATA_HI, 8'hFF, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_ADDR_LO, 8'h00, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_ADDR_HI, 8'h00, 9'h000);
    // all levels at the top
    push_txn(prce_pkg::MODE_LOOKUP, prce_pkg::PORT_ADDR_LO, 8'h00, 9'h1FF);
    // bit 8 set, clock mode 0
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_ADDR_HI, 8'hF3, 9'h000);
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_ADDR_LO, 8'hFF, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_DATA_LO, 8'h00, 9'h000);
    // read also wraps the address
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_DATA_HI, 8'h00, 9'h000);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_ADDR_LO, 8'h00, 9'h000);
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_DATA_LO, 8'hAA, 9'h000);
    push_txn(prce_pkg::MODE_WRITE,  prce_pkg::PORT_DATA_HI, 8'hFE, 9'h000);
    // mixed levels
    push_txn(prce_pkg::MODE_LOOKUP, prce_pkg::PORT_DATA_HI, 8'hFF, 9'h000);
    // undefined mode
    push_txn(MODE_NONE,             prce_pkg::PORT_DATA_HI, 8'hFF, 9'h1FF);
    push_txn(prce_pkg::MODE_READ,   prce_pkg::PORT_DATA_HI, 8'hFF, 9'h1FF);
    push_txn(prce_pkg::MODE_LOOKUP, prce_pkg::PORT_ADDR_LO, 8'hFF, 9'h000);

    // random part: mostly address setup, entry bursts, read back and lookups
    while (pending_txns.size() < RANDOM_TXNS + 25) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      kind    = $urandom_range(0, 9);
      if (kind < 2) begin
        // noise, undefined mode included
        repeat ($urandom_range(1, 6))
          push_txn(2'($urandom), 2'($urandom), 8'($urandom), 9'($urandom));
      end else begin
        base = (kind == 2) ? $urandom_range(500, 511) : $urandom_range(0, 511);
        n    = $urandom_range(1, 8);
        push_txn(prce_pkg::MODE_WRITE, prce_pkg::PORT_ADDR_LO, base[7:0], 9'($urandom));
        push_txn(prce_pkg::MODE_WRITE, prce_pkg::PORT_ADDR_HI, {7'($urandom), base[8]},
                 9'($urandom));
        repeat (n) begin
          push_txn(prce_pkg::MODE_WRITE, prce_pkg::PORT_DATA_LO, 8'($urandom), 9'($urandom));
          push_txn(prce_pkg::MODE_WRITE, prce_pkg::PORT_DATA_HI, 8'($urandom), 9'($urandom));
        end
        if ($urandom_range(0, 1) != 0) begin
          // point back at the burst and read it through the bus
          push_txn(prce_pkg::MODE_WRITE, prce_pkg::PORT_ADDR_LO, base[7:0], 9'($urandom));
          push_txn(prce_pkg::MODE_WRITE, prce_pkg::PORT_ADDR_HI, {7'($urandom), base[8]},
                   9'($urandom));
          push_txn(prce_pkg::MODE_READ,
                   ($urandom_range(0, 1) != 0) ? prce_pkg::PORT_ADDR_LO
                                               : prce_pkg::PORT_ADDR_HI,
                   8'($urandom), 9'($urandom));
          repeat (n) begin
            push_txn(prce_pkg::MODE_READ, prce_pkg::PORT_DATA_LO, 8'($urandom), 9'($urandom));
            push_txn(prce_pkg::MODE_READ, prce_pkg::PORT_DATA_HI, 8'($urandom), 9'($urandom));
          end
        end
        for (int i = 0; i < n; i++)
          push_txn(prce_pkg::MODE_LOOKUP, 2'($urandom), 8'($urandom), 9'((base + i) & 511));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every transaction to be taken and every color to come back
    while (pending_txns.size() != 0 || start || expected_colors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_colors.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_colors.size()));

    if (mismatch_count == 0) begin
      $display("** palette_ram_color_encoder: PASSED **");
    end else begin
      $display("** palette_ram_color_encoder: FAILED **");
    end
    $finish;
  end

endmodule
